// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/dq_pkg.sv =====
`default_nettype none
package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW  = 2'd2;
  localparam logic [1:0] ST_LIST_EMPTY = 2'd3;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_LIST   = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] item;
  } cmd_t;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } op_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(idx) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/dq_ram.sv =====
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/dq_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"
module dq_fifo import dq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output logic      full,
  output logic      valid,
  output op_t       head
);

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QDEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !full)

endmodule
`default_nettype wire

// ===== src/dq_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module dq_front import dq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd_data,
  input  wire logic fifo_full,
  output logic      push,
  output op_t       push_op
);

  logic [IDX_W-1:0] front_index;
  logic [IDX_W-1:0] front_index_next;
  logic [CNT_W-1:0] occupancy;
  logic [CNT_W-1:0] occupancy_next;
  logic             accept;
  logic             has_op;
  logic             is_full;
  logic             is_empty;

  assign cmd_stall = fifo_full;
  assign accept    = cmd_valid && !fifo_full;
  assign is_full   = occupancy == CNT_W'(DEPTH);
  assign is_empty  = occupancy == '0;
  assign push      = accept && has_op;

  always_comb begin
    front_index_next = front_index;
    occupancy_next   = occupancy;
    has_op           = 1'b1;
    push_op.kind     = OP_STATUS;
    push_op.addr     = front_index;
    push_op.data     = cmd_data.item;
    push_op.status   = ST_OK;
    push_op.count    = occupancy;
    case (cmd_data.command)
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          push_op.status = ST_OVERFLOW;
        end else begin
          front_index_next = (front_index == '0) ? IDX_W'(DEPTH - 1)
                                                 : front_index - IDX_W'(1);
          occupancy_next   = occupancy + CNT_W'(1);
          push_op.kind     = OP_WRITE;
          push_op.addr     = front_index_next;
        end
      end
      CMD_PUSH_BACK: begin
        if (is_full) begin
          push_op.status = ST_OVERFLOW;
        end else begin
          occupancy_next = occupancy + CNT_W'(1);
          push_op.kind   = OP_WRITE;
          push_op.addr   = ring_add(front_index, occupancy);
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          push_op.status = ST_UNDERFLOW;
        end else begin
          front_index_next = ring_add(front_index, CNT_W'(1));
          occupancy_next   = occupancy - CNT_W'(1);
          push_op.kind     = OP_READ;
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          push_op.status = ST_UNDERFLOW;
        end else begin
          occupancy_next = occupancy - CNT_W'(1);
          push_op.kind   = OP_READ;
          push_op.addr   = ring_add(front_index, occupancy - CNT_W'(1));
        end
      end
      CMD_LIST: begin
        if (is_empty) begin
          push_op.status = ST_LIST_EMPTY;
        end else begin
          push_op.kind = OP_LIST;
        end
      end
      default: begin
        has_op = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      occupancy   <= '0;
    end else if (accept) begin
      front_index <= front_index_next;
      occupancy   <= occupancy_next;
    end
  end

  `ASSERT_IMPLIES(a_occ_bound, clk, rst, 1'b1, occupancy <= CNT_W'(DEPTH))

endmodule
`default_nettype wire

// ===== src/dq_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module dq_back import dq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fifo_valid,
  input  wire op_t  head,
  output logic      pop,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res_data
);

  logic [CNT_W-1:0] list_pos;
  logic             list_last;
  logic             issue;
  logic             is_list;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             b_valid;
  logic             b_read;
  logic [1:0]       b_status;
  logic             b_last;

  assign is_list   = head.kind == OP_LIST;
  assign list_last = (list_pos + CNT_W'(1)) == head.count;
  assign issue     = fifo_valid && (!b_valid || !res_stall);
  assign pop       = issue && (!is_list || list_last);
  assign wr_en     = issue && head.kind == OP_WRITE;
  assign rd_en     = issue && (head.kind == OP_READ || is_list);
  assign rd_addr   = is_list ? ring_add(head.addr, list_pos) : head.addr;

  dq_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head.addr),
    .wr_data (head.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      list_pos <= '0;
    end else begin
      if (issue) begin
        b_valid <= 1'b1;
      end else if (!res_stall) begin
        b_valid <= 1'b0;
      end
      if (issue && is_list) begin
        list_pos <= list_last ? '0 : list_pos + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_read   <= head.kind == OP_READ || is_list;
      b_status <= (head.kind == OP_STATUS) ? head.status : ST_OK;
      b_last   <= is_list ? list_last : 1'b1;
    end
  end

  assign res_valid       = b_valid;
  assign res_data.value  = b_read ? rd_data : 8'd0;
  assign res_data.status = b_status;
  assign res_data.last   = b_last;

  `ASSERT_IMPLIES(a_list_head, clk, rst, list_pos != '0, fifo_valid && is_list)
  `ASSERT_IMPLIES(a_plain_last, clk, rst, b_valid && !b_read, b_last)

endmodule
`default_nettype wire

// ===== src/double_ended_queue.sv =====
// Bounded double-ended queue of bytes held in a ring of DEPTH entries.
// Commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd_data) and
// results leave on the res channel (res_valid, res_stall, res_data).
// Push front, push back, pop front and pop back each give one result: ok,
// overflow when full, or the popped byte, or underflow when empty.
// A list command gives one result per held byte, front to back, with last
// set on the final one, or a single listed-queue-empty result.
// The front part updates the ring pointers and queues an operation in a
// four-entry queue; the back part performs the byte-store access and
// drives the result register.
// Each accepted operation is queued, then issued to the store and result
// register. Push and pop sustain one item per cycle without stalls; a list
// holds the back part while the single read port reads each held byte.
// Reset empties the queue; stored bytes are not cleared.
// While the receiver stalls, the result holds, the back part waits and the
// command channel stalls once the operation queue is full.
`default_nettype none
module double_ended_queue import dq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd_data,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res_data
);

  logic fifo_full;
  logic fifo_valid;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  head;

  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_op   (push_op)
  );

  dq_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (fifo_full),
    .valid   (fifo_valid),
    .head    (head)
  );

  dq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_valid (fifo_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

endmodule
`default_nettype wire
